>>> rtl/priority_bucket_queue_core_macros.svh
// Assertion macros for the bucketed priority queue.
// Used by the top level; no other dependencies.
`ifndef PRIORITY_BUCKET_QUEUE_CORE_MACROS_SVH
`define PRIORITY_BUCKET_QUEUE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// a holds at this edge implies b holds at the same edge
`define PBQ_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
	else $error("assertion failed");
// a holds at this edge implies b holds at the next edge
`define PBQ_ASSERT_NXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
	else $error("assertion failed");
`else
`define PBQ_ASSERT_IMP(label, clk, rst_n, a, b)
`define PBQ_ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

>>> rtl/pbq_pkg.sv
// Shared types, sizes and codes for the bucketed priority queue.
// No dependencies.
package pbq_pkg;
	localparam int MAX_LEVELS       = 16;
	localparam int ORDERS_PER_LEVEL = 16;
	localparam int LVL_W  = $clog2(MAX_LEVELS);
	localparam int NUM_W  = $clog2(MAX_LEVELS + 1);
	localparam int ORD_W  = (ORDERS_PER_LEVEL > 1) ? $clog2(ORDERS_PER_LEVEL) : 1;
	localparam int OCNT_W = $clog2(ORDERS_PER_LEVEL + 1);

	localparam logic [1:0] OP_ENQ    = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_LK_T   = 2'd2;
	localparam logic [1:0] OP_LK_TO  = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] task_id;
		logic [15:0] order_id;
		logic [7:0]  priority_level;
	} pbq_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        hit;
		logic        queue_empty;
		logic [15:0] front_task;
		logic [15:0] front_order;
		logic [7:0]  front_priority;
	} pbq_out_t;

	typedef struct packed {
		logic capture;
		logic idx_inc;
		logic k_clr;
		logic k_inc;
		logic rd_ord;
		logic rd_next;
		logic wr_shift;
		logic exec_enq;
		logic exec_dec;
		logic set_nf;
		logic set_hit;
		logic rd_front;
		logic load_out;
	} pbq_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       scan_stop;
		logic       found;
		logic       k_end;
		logic       ord_match;
		logic       shift_end;
		logic       out_free;
	} pbq_stat_t;
endpackage

>>> rtl/pbq_ctrl.sv
// Sequencer for the bucketed priority queue.
// Depends on pbq_pkg.
module pbq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pbq_pkg::pbq_stat_t stat,
	output pbq_pkg::pbq_cmd_t  cmd
);
	import pbq_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_SCAN  = 8'b0000_0010,
		S_O_RD  = 8'b0000_0100,
		S_O_CMP = 8'b0000_1000,
		S_SH_RD = 8'b0001_0000,
		S_SH_WR = 8'b0010_0000,
		S_FR_RD = 8'b0100_0000,
		S_FR_WT = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_SCAN;
				end
			end
			S_SCAN: begin
				if (!stat.scan_stop) begin
					cmd.idx_inc = 1'b1;
				end else begin
					case (stat.op)
						OP_ENQ: begin
							cmd.exec_enq = 1'b1;
							state_d      = S_FR_RD;
						end
						OP_REMOVE: begin
							if (stat.found) begin
								cmd.k_clr = 1'b1;
								state_d   = S_O_RD;
							end else begin
								cmd.set_nf = 1'b1;
								state_d    = S_FR_RD;
							end
						end
						OP_LK_T: begin
							cmd.set_hit = stat.found;
							state_d     = S_FR_RD;
						end
						default: begin
							cmd.k_clr = stat.found;
							state_d   = stat.found ? S_O_RD : S_FR_RD;
						end
					endcase
				end
			end
			S_O_RD: begin
				if (stat.k_end) begin
					cmd.set_nf = (stat.op == OP_REMOVE);
					state_d    = S_FR_RD;
				end else begin
					cmd.rd_ord = 1'b1;
					state_d    = S_O_CMP;
				end
			end
			S_O_CMP: begin
				if (stat.ord_match) begin
					if (stat.op == OP_REMOVE) begin
						state_d = S_SH_RD;
					end else begin
						cmd.set_hit = 1'b1;
						state_d     = S_FR_RD;
					end
				end else begin
					cmd.k_inc = 1'b1;
					state_d   = S_O_RD;
				end
			end
			S_SH_RD: begin
				if (stat.shift_end) begin
					cmd.exec_dec = 1'b1;
					state_d      = S_FR_RD;
				end else begin
					cmd.rd_next = 1'b1;
					state_d     = S_SH_WR;
				end
			end
			S_SH_WR: begin
				cmd.wr_shift = 1'b1;
				cmd.k_inc    = 1'b1;
				state_d      = S_SH_RD;
			end
			S_FR_RD: begin
				cmd.rd_front = 1'b1;
				state_d      = S_FR_WT;
			end
			S_FR_WT: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

>>> rtl/pbq_dp.sv
// Datapath: entry table, slot map, order memory and result register.
// Depends on pbq_pkg.
module pbq_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  pbq_pkg::pbq_in_t   in_data,
	input  pbq_pkg::pbq_cmd_t  cmd,
	output pbq_pkg::pbq_stat_t stat,
	output logic               out_valid,
	input  logic               out_ready,
	output pbq_pkg::pbq_out_t  out_data
);
	import pbq_pkg::*;

	pbq_in_t            req_q;
	logic [1:0]         status_q;
	logic               hit_q;
	logic [NUM_W-1:0]   num_q;
	logic [NUM_W-1:0]   idx_q;
	logic [OCNT_W-1:0]  k_q;
	logic [7:0]         prio_q [MAX_LEVELS];
	logic [15:0]        task_q [MAX_LEVELS];
	logic [LVL_W-1:0]   slot_q [MAX_LEVELS];
	logic [OCNT_W-1:0]  ocnt_q [MAX_LEVELS];
	logic [MAX_LEVELS-1:0] free_q;
	logic [15:0]        mem [MAX_LEVELS][ORDERS_PER_LEVEL];
	logic [15:0]        rdata_q;
	logic               out_valid_q;
	pbq_out_t           out_q;

	logic [LVL_W-1:0]   ix;
	logic [OCNT_W-1:0]  cur_cnt;
	logic [LVL_W-1:0]   cur_slot;
	logic [OCNT_W-1:0]  kp1;
	logic               at_end;
	logic               eq_hit;
	logic [LVL_W-1:0]   alloc;
	logic               do_append;
	logic               do_insert;
	logic               del_entry;

	assign ix       = idx_q[LVL_W-1:0];
	assign cur_cnt  = ocnt_q[ix];
	assign cur_slot = slot_q[ix];
	assign kp1      = k_q + 1'b1;
	assign at_end   = (idx_q == num_q);
	assign eq_hit   = (req_q.operation == OP_ENQ) ? (prio_q[ix] == req_q.priority_level)
		: (task_q[ix] == req_q.task_id);

	always_comb begin
		alloc = '0;
		for (int s = MAX_LEVELS - 1; s >= 0; s--) begin
			if (free_q[s]) begin
				alloc = LVL_W'(s);
			end
		end
	end

	assign do_append = cmd.exec_enq && !at_end && eq_hit
		&& (cur_cnt != OCNT_W'(ORDERS_PER_LEVEL));
	assign do_insert = cmd.exec_enq && !(!at_end && eq_hit)
		&& (num_q != NUM_W'(MAX_LEVELS));
	assign del_entry = cmd.exec_dec && (cur_cnt == OCNT_W'(1));

	always_comb begin
		stat.op        = req_q.operation;
		stat.scan_stop = at_end || ((req_q.operation == OP_ENQ)
			? (prio_q[ix] <= req_q.priority_level) : eq_hit);
		stat.found     = !at_end && eq_hit;
		stat.k_end     = (k_q == cur_cnt);
		stat.ord_match = (rdata_q == req_q.order_id);
		stat.shift_end = (kp1 >= cur_cnt);
		stat.out_free  = !out_valid_q || out_ready;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q       <= '0;
			free_q      <= '1;
			out_valid_q <= 1'b0;
			for (int j = 0; j < MAX_LEVELS; j++) begin
				ocnt_q[j] <= '0;
			end
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (do_append) begin
				ocnt_q[ix] <= cur_cnt + 1'b1;
			end
			if (do_insert) begin
				num_q         <= num_q + 1'b1;
				free_q[alloc] <= 1'b0;
				for (int j = 1; j < MAX_LEVELS; j++) begin
					if (LVL_W'(j) > ix) begin
						ocnt_q[j] <= ocnt_q[j-1];
					end
				end
				ocnt_q[ix] <= OCNT_W'(1);
			end
			if (cmd.exec_dec) begin
				if (del_entry) begin
					num_q            <= num_q - 1'b1;
					free_q[cur_slot] <= 1'b1;
					for (int j = 0; j < MAX_LEVELS - 1; j++) begin
						if (LVL_W'(j) >= ix) begin
							ocnt_q[j] <= ocnt_q[j+1];
						end
					end
				end else begin
					ocnt_q[ix] <= cur_cnt - 1'b1;
				end
			end
		end
	end

	// entry payload, counters and request
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q    <= in_data;
			status_q <= ST_OK;
			hit_q    <= 1'b0;
			idx_q    <= '0;
		end
		if (cmd.idx_inc) begin
			idx_q <= idx_q + 1'b1;
		end
		if (cmd.k_clr) begin
			k_q <= '0;
		end else if (cmd.k_inc) begin
			k_q <= kp1;
		end
		if (cmd.set_nf) begin
			status_q <= ST_NOTFOUND;
		end
		if (cmd.set_hit) begin
			hit_q <= 1'b1;
		end
		if (cmd.exec_enq && !do_append && !do_insert) begin
			status_q <= ST_FULL;
		end
		if (do_insert) begin
			for (int j = 1; j < MAX_LEVELS; j++) begin
				if (LVL_W'(j) > ix) begin
					prio_q[j] <= prio_q[j-1];
					task_q[j] <= task_q[j-1];
					slot_q[j] <= slot_q[j-1];
				end
			end
			prio_q[ix] <= req_q.priority_level;
			task_q[ix] <= req_q.task_id;
			slot_q[ix] <= alloc;
		end
		if (del_entry) begin
			for (int j = 0; j < MAX_LEVELS - 1; j++) begin
				if (LVL_W'(j) >= ix) begin
					prio_q[j] <= prio_q[j+1];
					task_q[j] <= task_q[j+1];
					slot_q[j] <= slot_q[j+1];
				end
			end
		end
	end

	// order memory: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (do_append) begin
			mem[cur_slot][cur_cnt[ORD_W-1:0]] <= req_q.order_id;
		end else if (do_insert) begin
			mem[alloc][0] <= req_q.order_id;
		end else if (cmd.wr_shift) begin
			mem[cur_slot][k_q[ORD_W-1:0]] <= rdata_q;
		end
		if (cmd.rd_ord) begin
			rdata_q <= mem[cur_slot][k_q[ORD_W-1:0]];
		end else if (cmd.rd_next) begin
			rdata_q <= mem[cur_slot][kp1[ORD_W-1:0]];
		end else if (cmd.rd_front) begin
			rdata_q <= mem[slot_q[0]][0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.status      <= status_q;
			out_q.hit         <= hit_q;
			out_q.queue_empty <= (num_q == '0);
			if (num_q == '0) begin
				out_q.front_task     <= '0;
				out_q.front_order    <= '0;
				out_q.front_priority <= '0;
			end else begin
				out_q.front_task     <= task_q[0];
				out_q.front_order    <= rdata_q;
				out_q.front_priority <= prio_q[0];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule

>>> rtl/priority_bucket_queue_core.sv
// Top level of the bucketed priority queue: sequencer plus datapath.
// Depends on pbq_pkg, pbq_ctrl, pbq_dp and priority_bucket_queue_core_macros.svh.
//
// channel  direction  handshake            payload
// in       input      in_valid / in_ready   in_data  (pbq_in_t)
// out      output     out_valid / out_ready out_data (pbq_out_t)
//
// One transaction at a time. Each item is accepted, then the entries are scanned,
// then each order compared is read and checked, on removal each order behind the
// match is read and written back one place lower, a step ends an order walk on a
// miss or closes a removal, and the front order is read before the result loads.
// A result still waiting in the output register adds its wait to the last step.
// The result register frees the input side while a result waits to be taken.
// Reset empties the table at once; no clearing pass.
`include "priority_bucket_queue_core_macros.svh"
module priority_bucket_queue_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pbq_pkg::pbq_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output pbq_pkg::pbq_out_t out_data
);
	import pbq_pkg::*;

	pbq_cmd_t  cmd;
	pbq_stat_t stat;

	// sequencer: entry scan, order search, FIFO compaction, front read
	pbq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// table, slot map and the order memory
	pbq_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// a taken transaction keeps the input closed at the next edge
	`PBQ_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	// status never takes the unused code
	`PBQ_ASSERT_IMP(a_status_legal, clk, arst_n, out_valid, out_data.status != 2'd3)
	// an empty queue shows a zero front
	`PBQ_ASSERT_IMP(a_empty_front, clk, arst_n, out_valid && out_data.queue_empty,
		out_data.front_task == 16'd0 && out_data.front_priority == 8'd0)
	// a hit comes only from a lookup, which never sets a failing status, so a hit always reports ok
	`PBQ_ASSERT_IMP(a_hit_ok, clk, arst_n, out_valid && out_data.hit,
		out_data.status == ST_OK)
endmodule
